[src/two_key_sorted_priority_queue_core_assert.svh]
// Assertion macros for the two-key sorted priority queue core.
`ifndef TWO_KEY_SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define TWO_KEY_SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define TKPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define TKPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/tkpq_pkg.sv]
// Shared types and codes for the two-key sorted priority queue.
`default_nettype none

package tkpq_pkg;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // contents of one slot of the row
    typedef struct packed {
        logic        valid;
        logic [15:0] pri;
        logic [7:0]  age;
        logic [15:0] tag;
    } t_slot;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic eval;
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/tkpq_cell.sv]
// One slot cell of the sorted row: compare, insert-shift and pop-shift.
`default_nettype none

module tkpq_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tkpq_pkg::t_cell_ctl i_ctl,
    input  wire logic [15:0]       i_new_pri,
    input  wire logic [7:0]        i_new_age,
    input  wire logic [15:0]       i_new_tag,
    input  wire tkpq_pkg::t_slot   i_left,
    input  wire logic              i_left_before,
    input  wire tkpq_pkg::t_slot   i_right,
    output tkpq_pkg::t_slot        o_slot,
    output logic                   o_before,
    output logic                   o_match
);
    import tkpq_pkg::*;

    logic        r_valid;
    logic [15:0] r_pri;
    logic [7:0]  r_age;
    logic [15:0] r_tag;
    logic        r_before;
    logic        r_match;

    t_slot n_slot;
    logic  n_before;
    logic  n_match;

    // new word sorts ahead of this slot (an empty slot counts as after it)
    assign n_before = !r_valid || (r_pri > i_new_pri) ||
                      ((r_pri == i_new_pri) && (r_age < i_new_age));
    assign n_match  = r_valid && (r_pri == i_new_pri) && (r_age == i_new_age);

    always_comb begin
        n_slot = '{valid: r_valid, pri: r_pri, age: r_age, tag: r_tag};
        if (i_ctl.push && r_before) begin
            if (i_left_before) begin
                n_slot = i_left;
            end else begin
                n_slot = '{valid: 1'b1, pri: i_new_pri, age: i_new_age, tag: i_new_tag};
            end
        end else if (i_ctl.pop) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_before <= 1'b0;
            r_match  <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
            if (i_ctl.eval) begin
                r_before <= n_before;
                r_match  <= n_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_slot.pri;
        r_age <= n_slot.age;
        r_tag <= n_slot.tag;
    end

    assign o_slot   = '{valid: r_valid, pri: r_pri, age: r_age, tag: r_tag};
    assign o_before = r_before;
    assign o_match  = r_match;

endmodule

`default_nettype wire

[src/two_key_sorted_priority_queue_core.sv]
// Top level of the two-key sorted priority queue: sequencer, cell row, result register.
`default_nettype none

// Sorted queue of up to QUEUE_DEPTH entries (tag, priority, age), ordered by
// ascending priority and, within equal priority, descending age; slot 0 is
// the head. Command 0 pushes a word, command 1 pops the head. Each input word
// yields exactly one result word with status (ok, duplicate, full, pop on
// empty), the head after the operation, the clashing entry on a duplicate,
// and the occupancy. The state lives in a row of identical cells, one per
// slot; every cell compares against the incoming word in parallel and shifts
// from its left neighbor (insert) or right neighbor (pop), so latency does
// not grow with depth. A word passes from acceptance to its result through
// the steps accept, compare in all cells, shift and report; the sequencer
// handles one word at a time. A new word is taken while the previous result
// still waits in the output register; the report step waits only if that
// result has not been taken by then.
// Occupancy shows the low 5 bits of the entry count.

module two_key_sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_command,
    input  wire logic [15:0] i_entry_tag,
    input  wire logic [15:0] i_entry_priority,
    input  wire logic [7:0]  i_entry_age,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_head_valid,
    output logic [15:0]      o_head_tag,
    output logic [15:0]      o_head_priority,
    output logic [15:0]      o_clash_tag,
    output logic [15:0]      o_clash_priority,
    output logic [4:0]       o_occupancy
);
    import tkpq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_REPORT
    } t_state;

    t_state r_state;

    // latched input word
    logic        r_cmd;
    logic [15:0] r_tag;
    logic [15:0] r_pri;
    logic [7:0]  r_age;

    logic [CW-1:0] r_count;

    // outcome of the apply step
    logic [1:0]  r_res_status;
    logic [15:0] r_res_ctag;
    logic [15:0] r_res_cpri;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic        r_head_valid;
    logic [15:0] r_head_tag;
    logic [15:0] r_head_pri;
    logic [15:0] r_clash_tag;
    logic [15:0] r_clash_pri;
    logic [4:0]  r_occ;

    t_cell_ctl  cell_ctl;
    t_slot      slots    [QUEUE_DEPTH];
    logic       before_v [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] match_v;
    logic [QUEUE_DEPTH-1:0] valid_v;

    logic        any_match;
    logic [15:0] clash_tag;
    logic [15:0] clash_pri;
    logic        head_ok;
    logic        tail_full;
    logic        push_go;
    logic        pop_go;
    logic [1:0]  n_status;
    logic        out_free;
    logic        report_go;
    logic        in_fire;
    logic [CW+4:0] occ_wide;
    logic [CW-1:0] cells_used;
    logic        valid_hole;

    // ---------------------------------------------------------------- cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_slot left_s;
        t_slot right_s;
        logic  left_b;

        if (g == 0) begin : g_first
            assign left_s = '0;
            assign left_b = 1'b0;
        end else begin : g_mid
            assign left_s = slots[g-1];
            assign left_b = before_v[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_s = '0;
        end else begin : g_inner
            assign right_s = slots[g+1];
        end

        tkpq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_new_pri     (r_pri),
            .i_new_age     (r_age),
            .i_new_tag     (r_tag),
            .i_left        (left_s),
            .i_left_before (left_b),
            .i_right       (right_s),
            .o_slot        (slots[g]),
            .o_before      (before_v[g]),
            .o_match       (match_v[g])
        );

        assign valid_v[g] = slots[g].valid;
    end

    // ------------------------------------------------- clash reduce / decide
    // At most one stored entry can match, so an OR of masked fields picks it.
    always_comb begin
        clash_tag = '0;
        clash_pri = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            clash_tag = clash_tag | (slots[k].tag & {16{match_v[k]}});
            clash_pri = clash_pri | (slots[k].pri & {16{match_v[k]}});
        end
    end

    assign any_match = |match_v;
    assign head_ok   = slots[0].valid;
    assign tail_full = slots[QUEUE_DEPTH-1].valid;

    always_comb begin
        case (r_cmd)
            CMD_POP:  n_status = head_ok ? ST_OK : ST_EMPTY;
            CMD_PUSH: n_status = any_match ? ST_DUP : (tail_full ? ST_FULL : ST_OK);
            default:  n_status = ST_OK;
        endcase
    end

    assign push_go = (r_state == S_APPLY) && (r_cmd == CMD_PUSH) && !any_match && !tail_full;
    assign pop_go  = (r_state == S_APPLY) && (r_cmd == CMD_POP) && head_ok;

    assign cell_ctl = '{eval: (r_state == S_EVAL), push: push_go, pop: pop_go};

    assign out_free  = !r_out_valid || i_out_ready;
    assign report_go = (r_state == S_REPORT) && out_free;
    assign in_fire   = i_in_valid && o_in_ready;
    assign occ_wide  = {5'd0, r_count};

    // -------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace one taken in the same cycle
            if (report_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (push_go) begin
                        r_count <= r_count + CW'(1);
                    end else if (pop_go) begin
                        r_count <= r_count - CW'(1);
                    end
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_cmd <= i_command;
            r_tag <= i_entry_tag;
            r_pri <= i_entry_priority;
            r_age <= i_entry_age;
        end
        if (r_state == S_APPLY) begin
            r_res_status <= n_status;
            r_res_ctag   <= (n_status == ST_DUP) ? clash_tag : 16'd0;
            r_res_cpri   <= (n_status == ST_DUP) ? clash_pri : 16'd0;
        end
        if (report_go) begin
            r_status     <= r_res_status;
            r_head_valid <= slots[0].valid;
            r_head_tag   <= slots[0].valid ? slots[0].tag : 16'd0;
            r_head_pri   <= slots[0].valid ? slots[0].pri : 16'd0;
            r_clash_tag  <= r_res_ctag;
            r_clash_pri  <= r_res_cpri;
            r_occ        <= occ_wide[4:0];
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_head_valid     = r_head_valid;
    assign o_head_tag       = r_head_tag;
    assign o_head_priority  = r_head_pri;
    assign o_clash_tag      = r_clash_tag;
    assign o_clash_priority = r_clash_pri;
    assign o_occupancy      = r_occ;

    // ------------------------------------------------------------- assertions
`include "two_key_sorted_priority_queue_core_assert.svh"

    assign cells_used = CW'($countones(valid_v));
    assign valid_hole = |((valid_v >> 1) & ~valid_v);

    // entry count tracks the number of occupied cells
    `TKPQ_ASSERT_NOW(a_count_cells, i_clk, i_rst_n, 1'b1, r_count == cells_used, "count vs cells")

    // occupied cells form a prefix of the row
    `TKPQ_ASSERT_NOW(a_valid_prefix, i_clk, i_rst_n, 1'b1, !valid_hole, "hole in occupied cells")

    // an accepted word always starts the compare step
    `TKPQ_ASSERT_NEXT(a_acc_eval, i_clk, i_rst_n, in_fire, r_state == S_EVAL, "missed compare")

endmodule

`default_nettype wire
